@@ design/dws_pkg.sv @@
// shared types, codes and the microcode table for the deque with search
// no dependencies
package dws_pkg;

    typedef enum logic [2:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_SEARCH     = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // microprogram addresses
    typedef enum logic [3:0] {
        S_FETCH = 4'd0,
        S_PUSHF = 4'd1,
        S_PUSHB = 4'd2,
        S_POPF  = 4'd3,
        S_POPB  = 4'd4,
        S_NOP   = 4'd5,
        S_SINIT = 4'd6,
        S_SRD   = 4'd7,
        S_SCMP  = 4'd8,
        S_EMIT  = 4'd9
    } t_step;

    // datapath action of one control word
    typedef enum logic [2:0] {
        A_NONE  = 3'd0,
        A_PUSHF = 3'd1,
        A_PUSHB = 3'd2,
        A_POPF  = 3'd3,
        A_POPB  = 3'd4,
        A_SINIT = 3'd5,
        A_SREAD = 3'd6,
        A_SCMP  = 3'd7
    } t_act;

    // sequencing condition of one control word
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_WAIT_IN  = 3'd1,
        C_SKIP_EMP = 3'd2,
        C_MORE     = 3'd3,
        C_OUT_FREE = 3'd4
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  emit;
        t_act  act;
        t_cond cond;
        t_step next;
    } t_ctl;

    function automatic t_ctl ucode(input t_step s);
        t_ctl c;
        c = '{accept: 1'b0, emit: 1'b0, act: A_NONE, cond: C_NEXT, next: S_FETCH};
        case (s)
            S_FETCH: c = '{1'b1, 1'b0, A_NONE,  C_WAIT_IN,  S_FETCH};
            S_PUSHF: c = '{1'b0, 1'b0, A_PUSHF, C_NEXT,     S_EMIT};
            S_PUSHB: c = '{1'b0, 1'b0, A_PUSHB, C_NEXT,     S_EMIT};
            S_POPF:  c = '{1'b0, 1'b0, A_POPF,  C_NEXT,     S_EMIT};
            S_POPB:  c = '{1'b0, 1'b0, A_POPB,  C_NEXT,     S_EMIT};
            S_NOP:   c = '{1'b0, 1'b0, A_NONE,  C_NEXT,     S_EMIT};
            S_SINIT: c = '{1'b0, 1'b0, A_SINIT, C_SKIP_EMP, S_SRD};
            S_SRD:   c = '{1'b0, 1'b0, A_SREAD, C_NEXT,     S_SCMP};
            S_SCMP:  c = '{1'b0, 1'b0, A_SCMP,  C_MORE,     S_SRD};
            S_EMIT:  c = '{1'b0, 1'b1, A_NONE,  C_OUT_FREE, S_FETCH};
            default: c = '{1'b0, 1'b0, A_NONE,  C_NEXT,     S_FETCH};
        endcase
        return c;
    endfunction

endpackage

@@ design/dws_in_if.sv @@
// operation channel of the deque with search: valid, ready, selector and value
// no dependencies
interface dws_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

@@ design/dws_out_if.sv @@
// result channel of the deque with search: valid, ready, status, found and count
// no dependencies; COUNT_W must match the count width of the block
interface dws_out_if #(
    parameter int COUNT_W = 5
);
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               found;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output status, output found, output count, input ready);
    modport sink   (input valid, input status, input found, input count, output ready);
endinterface

@@ design/deque_with_search.sv @@
// deque with search: push, pop and unused selectors go fetch, action step, emit; a search
// goes fetch, init, then a read and a compare step per entry read up to and including the
// first match (every held entry on a miss), through the single read port of the entry memory
// one operation at a time; the result register frees the input while a result waits
// reset (synchronous, active low) empties the queue; entry memory is not cleared
// depends on dws_pkg, dws_in_if, dws_out_if
module deque_with_search #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dws_in_if.sink    i_in,
    dws_out_if.source o_out
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

    // sequencer
    dws_pkg::t_step r_step, n_step;
    dws_pkg::t_ctl  ctl;

    // queue state
    logic [IW-1:0] r_front;
    logic [CW-1:0] r_count;

    // operation being worked on
    logic [2:0]         r_func;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_idx;
    dws_pkg::t_status   r_status;
    logic               r_found;

    // result register
    logic             r_out_valid;
    dws_pkg::t_status r_out_status;
    logic             r_out_found;
    logic [CW-1:0]    r_out_count;

    // entry memory
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;

    logic          full, empty, hit, out_free, wr_en;
    logic [IW-1:0] front_dec, front_inc, back_addr, rd_addr, wr_addr;

    // (a + b) mod CAPACITY for a < CAPACITY, b <= CAPACITY
    function automatic logic [IW-1:0] wrap(input logic [CW:0] s);
        logic [CW:0] t;
        t = (s >= CAP_W) ? s - CAP_W : s;
        return t[IW-1:0];
    endfunction

    assign full      = (r_count == CAP_C);
    assign empty     = (r_count == '0);
    assign hit       = (r_rd_data == r_value);
    assign out_free  = !r_out_valid || o_out.ready;
    assign front_dec = (r_front == '0) ? LAST_I : r_front - 1'b1;
    assign front_inc = (r_front == LAST_I) ? '0 : r_front + 1'b1;
    assign back_addr = wrap((CW + 1)'(r_front) + (CW + 1)'(r_count));
    assign rd_addr   = wrap((CW + 1)'(r_front) + (CW + 1)'(r_idx));

    // control word fetch and next step
    always_comb begin
        ctl    = dws_pkg::ucode(r_step);
        n_step = ctl.next;
        case (ctl.cond)
            dws_pkg::C_NEXT: n_step = ctl.next;
            dws_pkg::C_WAIT_IN: begin
                // dispatch on the selector of the incoming transfer
                if (!i_in.valid) begin
                    n_step = r_step;
                end else begin
                    case (dws_pkg::t_func'(i_in.func))
                        dws_pkg::FUNC_PUSH_FRONT: n_step = dws_pkg::S_PUSHF;
                        dws_pkg::FUNC_PUSH_BACK:  n_step = dws_pkg::S_PUSHB;
                        dws_pkg::FUNC_POP_FRONT:  n_step = dws_pkg::S_POPF;
                        dws_pkg::FUNC_POP_BACK:   n_step = dws_pkg::S_POPB;
                        dws_pkg::FUNC_SEARCH:     n_step = dws_pkg::S_SINIT;
                        default:                  n_step = dws_pkg::S_NOP;
                    endcase
                end
            end
            // empty queue: nothing to search
            dws_pkg::C_SKIP_EMP: n_step = empty ? dws_pkg::S_EMIT : ctl.next;
            // keep reading until a match or the last held entry
            dws_pkg::C_MORE:
                n_step = (!hit && (r_idx < r_count)) ? ctl.next : dws_pkg::S_EMIT;
            // hold the result until the result register is free
            dws_pkg::C_OUT_FREE: n_step = out_free ? ctl.next : r_step;
            default: n_step = ctl.next;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dws_pkg::S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign i_in.ready = ctl.accept;

    // write port: a refused push leaves the memory alone
    assign wr_en   = !full && (ctl.act == dws_pkg::A_PUSHF || ctl.act == dws_pkg::A_PUSHB);
    assign wr_addr = (ctl.act == dws_pkg::A_PUSHF) ? front_dec : back_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            case (ctl.act)
                dws_pkg::A_PUSHF: begin
                    if (!full) begin
                        r_front <= front_dec;
                        r_count <= r_count + 1'b1;
                    end
                end
                dws_pkg::A_PUSHB: begin
                    if (!full) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                dws_pkg::A_POPF: begin
                    if (!empty) begin
                        r_front <= front_inc;
                        r_count <= r_count - 1'b1;
                    end
                end
                dws_pkg::A_POPB: begin
                    if (!empty) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // operation payload, status and search progress
    always_ff @(posedge i_clk) begin
        if (ctl.accept && i_in.valid) begin
            r_func   <= i_in.func;
            r_value  <= i_in.value;
            r_status <= dws_pkg::ST_OK;
            r_found  <= 1'b0;
        end
        case (ctl.act)
            dws_pkg::A_PUSHF, dws_pkg::A_PUSHB: begin
                if (full) begin
                    r_status <= dws_pkg::ST_FULL;
                end
            end
            dws_pkg::A_POPF, dws_pkg::A_POPB: begin
                if (empty) begin
                    r_status <= dws_pkg::ST_EMPTY;
                end
            end
            dws_pkg::A_SINIT: r_idx <= '0;
            dws_pkg::A_SREAD: r_idx <= r_idx + 1'b1;
            dws_pkg::A_SCMP: begin
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit && out_free) begin
            r_out_status <= r_status;
            // the search flag only ever counts for a search transfer
            r_out_found  <= r_found && (dws_pkg::t_func'(r_func) == dws_pkg::FUNC_SEARCH);
            r_out_count  <= r_count;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.found  = r_out_found;
    assign o_out.count  = r_out_count;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // a refused push is only reported on a full queue
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_out_status == dws_pkg::ST_FULL) |-> (r_out_count == CAP_C))
        else $error("full status with room left");

    // a refused pop is only reported on an empty queue
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_out_status == dws_pkg::ST_EMPTY) |-> (r_out_count == '0))
        else $error("empty status with entries held");

    // a search leaves the count alone
    a_search_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == dws_pkg::S_SCMP) |=> $stable(r_count))
        else $error("count changed during search");

endmodule

@@ bench/deque_with_search_test.sv @@
// self-checking bench for the deque with search: random and directed operations,
// a mirror of the deque, and a result check
// depends on dws_pkg, dws_in_if, dws_out_if and deque_with_search
module deque_with_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int N_RANDOM     = 1800;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES = 60;    // outlasts the longest search, one over all DEPTH entries
    localparam int CALM_TAIL    = 150;   // backlog size below which nobody idles
    localparam int HOLD_CYCLES  = 120;   // long output hold-off to back up the input

    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] V_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
    } t_op;

    typedef struct packed {
        dws_pkg::t_status status;
        logic             found;
        logic [4:0]       count;
    } t_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dws_in_if                op_ch ();
    dws_out_if #(.COUNT_W(5)) res_ch ();

    deque_with_search #(
        .CAPACITY (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // operations waiting to be offered, and replies still owed by the block
    t_op    op_backlog[$];
    t_reply awaited_replies[$];

    // values pushed lately, reused so that searches hit and pushes repeat
    logic signed [31:0] value_pool[$];

    // mirror of the deque: circular cells, front slot and fill level
    logic signed [31:0] mirror_cells [DEPTH];
    logic [3:0]         mirror_front = '0;
    logic [4:0]         mirror_held  = '0;

    int total_ops    = 0;
    int ops_taken    = 0;   // operations transferred into the block
    int replies_seen = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;   // tail of the run: no idling on either side

    // sender pacing
    int in_gap      = 0;
    int in_idle_pct = 10;

    // receiver pacing and the long hold-off
    int out_gap      = 0;
    int out_idle_pct = 10;
    int hold_left    = 0;
    int hold_stage   = 0;

    // apply one operation to the mirror and work out the reply it gives
    function automatic t_reply deque_apply(input logic [2:0] f, input logic signed [31:0] v);
        t_reply     r;
        logic [3:0] slot;
        r.status = dws_pkg::ST_OK;
        r.found  = 1'b0;
        case (f)
            dws_pkg::FUNC_PUSH_FRONT: begin
                if (mirror_held == DEPTH) begin
                    r.status = dws_pkg::ST_FULL;
                end else begin
                    mirror_front               = mirror_front - 4'd1;
                    mirror_cells[mirror_front] = v;
                    mirror_held                = mirror_held + 5'd1;
                end
            end
            dws_pkg::FUNC_PUSH_BACK: begin
                if (mirror_held == DEPTH) begin
                    r.status = dws_pkg::ST_FULL;
                end else begin
                    slot               = mirror_front + mirror_held[3:0];
                    mirror_cells[slot] = v;
                    mirror_held        = mirror_held + 5'd1;
                end
            end
            dws_pkg::FUNC_POP_FRONT: begin
                if (mirror_held == 0) begin
                    r.status = dws_pkg::ST_EMPTY;
                end else begin
                    mirror_front = mirror_front + 4'd1;
                    mirror_held  = mirror_held - 5'd1;
                end
            end
            dws_pkg::FUNC_POP_BACK: begin
                if (mirror_held == 0) begin
                    r.status = dws_pkg::ST_EMPTY;
                end else begin
                    mirror_held = mirror_held - 5'd1;
                end
            end
            dws_pkg::FUNC_SEARCH: begin
                // only held cells take part in the compare
                for (int k = 0; k < mirror_held; k++) begin
                    slot = mirror_front + 4'(k);
                    if (mirror_cells[slot] == v) r.found = 1'b1;
                end
            end
            default: ;  // unused selector: nothing moves
        endcase
        r.count = mirror_held;
        return r;
    endfunction

    function automatic void add_op(input logic [2:0] f, input logic signed [31:0] v);
        op_backlog.push_back('{func: f, value: v});
        if (f == dws_pkg::FUNC_PUSH_FRONT || f == dws_pkg::FUNC_PUSH_BACK) begin
            value_pool.push_back(v);
            if (value_pool.size() > DEPTH) void'(value_pool.pop_front());
        end
    endfunction

    // mix of corner values, fresh random words and recently pushed values
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = V_MIN;
                    1: v = V_MAX;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2, 3, 4: v = $urandom();
            default: begin
                if (value_pool.size() != 0)
                    v = value_pool[$urandom_range(0, value_pool.size() - 1)];
                else
                    v = $urandom();
            end
        endcase
        return v;
    endfunction

    // sender: offers the backlog, holds an item until its transfer, idles in bursts
    always @(posedge i_clk) begin
        t_op nxt;
        if (!i_rst_n) begin
            op_ch.valid <= 1'b0;
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                awaited_replies.push_back(deque_apply(op_ch.func, op_ch.value));
                ops_taken <= ops_taken + 1;
                // change the idling rate now and then, zero giving long busy stretches
                if (ops_taken % 64 == 63) begin
                    case ($urandom_range(0, 2))
                        0: in_idle_pct <= 0;
                        1: in_idle_pct <= 5;
                        default: in_idle_pct <= 25;
                    endcase
                end
            end
            calm <= (op_backlog.size() < CALM_TAIL);

            if (op_ch.valid && !op_ch.ready) begin
                // item still on offer: leave it untouched
            end else if (in_gap != 0) begin
                in_gap      <= in_gap - 1;
                op_ch.valid <= 1'b0;
            end else if (op_backlog.size() != 0 &&
                         (calm || hold_left != 0 || $urandom_range(0, 99) >= in_idle_pct)) begin
                nxt         = op_backlog.pop_front();
                op_ch.func  <= nxt.func;
                op_ch.value <= nxt.value;
                op_ch.valid <= 1'b1;
            end else if (op_backlog.size() != 0) begin
                // start an idle burst, this one included
                in_gap      <= $urandom_range(0, 12);
                op_ch.valid <= 1'b0;
            end else begin
                op_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus two long hold-offs so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready && replies_seen % 64 == 31) begin
                case ($urandom_range(0, 2))
                    0: out_idle_pct <= 0;
                    1: out_idle_pct <= 5;
                    default: out_idle_pct <= 25;
                endcase
            end

            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else if (hold_stage < 2 && ops_taken >= (hold_stage == 0 ? 400 : 1100)) begin
                hold_stage   <= hold_stage + 1;
                hold_left    <= HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else if (out_gap != 0) begin
                out_gap      <= out_gap - 1;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
                out_gap      <= $urandom_range(0, 12);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // result check: every transfer out against the oldest awaited reply
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            replies_seen <= replies_seen + 1;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: stray result: status %0d found %0d count %0d",
                             $realtime, res_ch.status, res_ch.found, res_ch.count);
            end else begin
                want = awaited_replies.pop_front();
                if (res_ch.status !== want.status || res_ch.found !== want.found ||
                    res_ch.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply %0d: exp %0d %0d %0d, got %0d %0d %0d",
                                 $realtime, replies_seen, want.status, want.found, want.count,
                                 res_ch.status, res_ch.found, res_ch.count);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("deque_with_search_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_left;
        int push_pct;
        int pop_pct;
        int roll;

        // directed: operations on an empty deque, unused selectors, corner values
        add_op(dws_pkg::FUNC_SEARCH, '0);
        add_op(dws_pkg::FUNC_POP_FRONT, V_MAX);
        add_op(dws_pkg::FUNC_POP_BACK, V_MIN);
        add_op(3'd5, -32'sd1);
        add_op(3'd6, V_MIN);
        add_op(3'd7, V_MAX);
        // front pushes wrap the front slot below zero
        add_op(dws_pkg::FUNC_PUSH_FRONT, V_MAX);
        add_op(dws_pkg::FUNC_PUSH_BACK, V_MIN);
        add_op(dws_pkg::FUNC_PUSH_FRONT, '0);
        add_op(dws_pkg::FUNC_PUSH_BACK, -32'sd1);
        add_op(dws_pkg::FUNC_PUSH_FRONT, 32'sd1);
        add_op(dws_pkg::FUNC_SEARCH, V_MAX);
        add_op(dws_pkg::FUNC_SEARCH, V_MIN);
        add_op(dws_pkg::FUNC_SEARCH, -32'sd1);
        add_op(dws_pkg::FUNC_SEARCH, 32'sd1);
        add_op(dws_pkg::FUNC_SEARCH, V_MAX - 32'sd1);
        add_op(dws_pkg::FUNC_POP_FRONT, '0);
        add_op(dws_pkg::FUNC_POP_BACK, '0);
        add_op(dws_pkg::FUNC_SEARCH, -32'sd1);
        add_op(3'd7, '0);
        add_op(dws_pkg::FUNC_POP_FRONT, '0);
        add_op(dws_pkg::FUNC_POP_BACK, '0);
        add_op(dws_pkg::FUNC_POP_FRONT, '0);
        add_op(dws_pkg::FUNC_POP_BACK, '0);

        // random: phases that lean towards filling, draining or neither,
        // so the deque often runs full and empty
        phase_left = 0;
        push_pct   = 35;
        pop_pct    = 35;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: begin push_pct = 60; pop_pct = 15; end
                    1: begin push_pct = 15; pop_pct = 60; end
                    default: begin push_pct = 35; pop_pct = 35; end
                endcase
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                add_op($urandom_range(0, 1) ? dws_pkg::FUNC_PUSH_BACK
                                            : dws_pkg::FUNC_PUSH_FRONT, pick_value());
            else if (roll < push_pct + pop_pct)
                add_op($urandom_range(0, 1) ? dws_pkg::FUNC_POP_BACK
                                            : dws_pkg::FUNC_POP_FRONT, $urandom());
            else if (roll < 96)
                add_op(dws_pkg::FUNC_SEARCH, pick_value());
            else
                add_op(3'($urandom_range(5, 7)), $urandom());
        end
        total_ops = op_backlog.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_taken < total_ops) @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
        // catch any stray result after the last one owed
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("deque_with_search_test OK");
        end else begin
            $display("deque_with_search_test NOT OK");
        end
        $finish;
    end

endmodule
